[hdl/rmq_pkg.sv]
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion package
// Shared types and constants for the pose to quaternion converter.
// ----------------------------------------------------------------------------
`default_nettype none

package rmq_pkg;

   localparam int ROT_W             = 16;
   localparam int TRANS_W           = 24;
   localparam int NUM_W             = 17;
   localparam int ROT_FRAC_BITS_DEF = 14;
   localparam int QUEUE_DEPTH       = 2;

   typedef enum logic [1:0] {
      BR_TRACE,
      BR_X,
      BR_Y,
      BR_Z
   } branch_type;

   typedef struct packed {
      logic signed [ROT_W-1:0]   rot_00;
      logic signed [ROT_W-1:0]   rot_01;
      logic signed [ROT_W-1:0]   rot_02;
      logic signed [ROT_W-1:0]   rot_10;
      logic signed [ROT_W-1:0]   rot_11;
      logic signed [ROT_W-1:0]   rot_12;
      logic signed [ROT_W-1:0]   rot_20;
      logic signed [ROT_W-1:0]   rot_21;
      logic signed [ROT_W-1:0]   rot_22;
      logic signed [TRANS_W-1:0] trans_x;
      logic signed [TRANS_W-1:0] trans_y;
      logic signed [TRANS_W-1:0] trans_z;
   } req_type;

   typedef struct packed {
      logic signed [TRANS_W-1:0] pos_x;
      logic signed [TRANS_W-1:0] pos_y;
      logic signed [TRANS_W-1:0] pos_z;
      logic signed [ROT_W-1:0]   quat_x;
      logic signed [ROT_W-1:0]   quat_y;
      logic signed [ROT_W-1:0]   quat_z;
      logic signed [ROT_W-1:0]   quat_w;
   } rsp_type;

   // The three small components in branch order: trace (x, y, z),
   // x largest (w, y, z), y largest (w, x, z), z largest (w, x, y).
   typedef struct packed {
      logic signed [TRANS_W-1:0] pos_x;
      logic signed [TRANS_W-1:0] pos_y;
      logic signed [TRANS_W-1:0] pos_z;
      logic signed [NUM_W-1:0]   num_a;
      logic signed [NUM_W-1:0]   num_b;
      logic signed [NUM_W-1:0]   num_c;
      branch_type                branch;
   } job_type;

endpackage

`default_nettype wire

[hdl/rmq_front.sv]
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion front end
// Accepts a pose, picks the branch and forms the root argument and numerators.
// ----------------------------------------------------------------------------
`default_nettype none

module rmq_front #(
   parameter int ROT_FRAC_BITS = rmq_pkg::ROT_FRAC_BITS_DEF,
   parameter int DW            = 18
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire rmq_pkg::req_type req_item,
   input  wire logic             q_full,
   output logic                  q_push,
   output rmq_pkg::job_type      job,
   output logic [DW-1:0]         d_val
);

   localparam int TW = DW + 1;
   localparam int NW = rmq_pkg::NUM_W;
   localparam logic signed [TW-1:0] ONE = TW'(64'sd1 <<< ROT_FRAC_BITS);

   logic                     valid_ff, valid_in;
   rmq_pkg::job_type         job_ff, job_in;
   logic [DW-1:0]            d_ff, d_in;
   logic                     accept;
   logic signed [TW-1:0]     m00, m11, m22, trace, d_s;

   assign busy   = valid_ff && q_full;
   assign accept = start && !busy;
   assign q_push = valid_ff && !q_full;
   assign job    = job_ff;
   assign d_val  = d_ff;

   always_comb begin
      m00    = TW'(req_item.rot_00);
      m11    = TW'(req_item.rot_11);
      m22    = TW'(req_item.rot_22);
      trace  = m00 + m11 + m22;
      job_in = job_ff;
      d_in   = d_ff;
      d_s    = ONE;
      if (accept) begin
         job_in.pos_x = req_item.trans_x;
         job_in.pos_y = req_item.trans_y;
         job_in.pos_z = req_item.trans_z;
         if (trace > 0) begin
            d_s           = trace + ONE;
            job_in.branch = rmq_pkg::BR_TRACE;
            job_in.num_a  = NW'(req_item.rot_21) - NW'(req_item.rot_12);
            job_in.num_b  = NW'(req_item.rot_02) - NW'(req_item.rot_20);
            job_in.num_c  = NW'(req_item.rot_10) - NW'(req_item.rot_01);
         end else if (req_item.rot_00 > req_item.rot_11 &&
                      req_item.rot_00 > req_item.rot_22) begin
            d_s           = ONE + m00 - m11 - m22;
            job_in.branch = rmq_pkg::BR_X;
            job_in.num_a  = NW'(req_item.rot_21) - NW'(req_item.rot_12);
            job_in.num_b  = NW'(req_item.rot_01) + NW'(req_item.rot_10);
            job_in.num_c  = NW'(req_item.rot_02) + NW'(req_item.rot_20);
         end else if (req_item.rot_11 > req_item.rot_22) begin
            d_s           = ONE + m11 - m00 - m22;
            job_in.branch = rmq_pkg::BR_Y;
            job_in.num_a  = NW'(req_item.rot_02) - NW'(req_item.rot_20);
            job_in.num_b  = NW'(req_item.rot_01) + NW'(req_item.rot_10);
            job_in.num_c  = NW'(req_item.rot_12) + NW'(req_item.rot_21);
         end else begin
            d_s           = ONE + m22 - m00 - m11;
            job_in.branch = rmq_pkg::BR_Z;
            job_in.num_a  = NW'(req_item.rot_10) - NW'(req_item.rot_01);
            job_in.num_b  = NW'(req_item.rot_02) + NW'(req_item.rot_20);
            job_in.num_c  = NW'(req_item.rot_12) + NW'(req_item.rot_21);
         end
         if (d_s < 1) begin
            d_s = TW'(1);
         end
         d_in = d_s[DW-1:0];
      end
      valid_in = accept || (valid_ff && q_full);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      job_ff <= job_in;
      d_ff   <= d_in;
   end

endmodule

`default_nettype wire

[hdl/rmq_queue.sv]
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion job queue
// Short first-in first-out buffer between the front end and the arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none

module rmq_queue #(
   parameter int DATA_W = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire logic [DATA_W-1:0] push_data,
   input  wire logic              pop,
   output logic [DATA_W-1:0]      pop_data,
   output logic                   empty,
   output logic                   full
);

   localparam int DEPTH = rmq_pkg::QUEUE_DEPTH;
   localparam int PW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] entry_ff [DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     count_ff, count_in;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == CW'(DEPTH));
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      push |-> (!full || pop)) else $error("Push into a full queue.");
   a_no_underflow : assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty) else $error("Pop from an empty queue.");
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH)) else $error("Queue count out of range.");

endmodule

`default_nettype wire

[hdl/rmq_back.sv]
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion arithmetic pipeline
// Pipelined square root, three pipelined dividers and output saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module rmq_back #(
   parameter int ROT_FRAC_BITS = rmq_pkg::ROT_FRAC_BITS_DEF,
   parameter int DW            = 18
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   input  wire rmq_pkg::job_type in_job,
   input  wire logic [DW-1:0]    in_d,
   output logic                  rsp_strobe,
   output rmq_pkg::rsp_type      rsp_item
);

   localparam int F   = ROT_FRAC_BITS;
   localparam int AW0 = DW + F;
   localparam int AW  = AW0 + (AW0 % 2);
   localparam int RW  = AW / 2;
   localparam int NW  = F + rmq_pkg::NUM_W;
   localparam int RMW = RW + 2;

   // Square root stages.
   logic             sq_valid_ff [RW+1];
   logic             sq_valid_in [RW+1];
   logic [RMW-1:0]   sq_rem_ff   [RW+1];
   logic [RMW-1:0]   sq_rem_in   [RW+1];
   logic [RW-1:0]    sq_root_ff  [RW+1];
   logic [RW-1:0]    sq_root_in  [RW+1];
   logic [AW-1:0]    sq_arg_ff   [RW+1];
   logic [AW-1:0]    sq_arg_in   [RW+1];
   rmq_pkg::job_type sq_job_ff   [RW+1];
   rmq_pkg::job_type sq_job_in   [RW+1];
   logic [RMW-1:0]   sq_rsh      [RW];
   logic [RMW-1:0]   sq_try      [RW];

   // Divider stages; index 0 is the preparation stage.
   logic             dv_valid_ff [NW+1];
   logic             dv_valid_in [NW+1];
   rmq_pkg::job_type dv_job_ff   [NW+1];
   rmq_pkg::job_type dv_job_in   [NW+1];
   logic [RW:0]      dv_div_ff   [NW+1];
   logic [RW:0]      dv_div_in   [NW+1];
   logic [15:0]      dv_big_ff   [NW+1];
   logic [15:0]      dv_big_in   [NW+1];
   logic [RMW-1:0]   dv_rem_ff   [NW+1][3];
   logic [RMW-1:0]   dv_rem_in   [NW+1][3];
   logic [NW-1:0]    dv_nq_ff    [NW+1][3];
   logic [NW-1:0]    dv_nq_in    [NW+1][3];
   logic [RMW-1:0]   dv_rsh      [NW][3];

   logic [RW-1:0]            root;
   logic [RW:0]              big_sum;
   logic [RW+15:0]           big_x;
   logic signed [rmq_pkg::NUM_W-1:0] num [3];
   logic [rmq_pkg::NUM_W-1:0] mag [3];
   logic signed [15:0]       comp [3];
   logic [NW-1:0]            quo;
   logic signed [15:0]       big_s;

   logic                     strobe_ff, strobe_in;
   rmq_pkg::rsp_type         rsp_ff, rsp_in;

   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;

   always_comb begin
      sq_valid_in[0] = in_valid;
      sq_rem_in[0]   = '0;
      sq_root_in[0]  = '0;
      sq_arg_in[0]   = AW'(in_d) << F;
      sq_job_in[0]   = in_job;
      for (int i = 0; i < RW; i++) begin
         sq_rsh[i]        = {sq_rem_ff[i][RW-1:0], sq_arg_ff[i][AW-1:AW-2]};
         sq_try[i]        = {sq_root_ff[i], 2'b01};
         sq_valid_in[i+1] = sq_valid_ff[i];
         sq_job_in[i+1]   = sq_job_ff[i];
         sq_arg_in[i+1]   = sq_arg_ff[i] << 2;
         if (sq_rsh[i] >= sq_try[i]) begin
            sq_rem_in[i+1]  = sq_rsh[i] - sq_try[i];
            sq_root_in[i+1] = {sq_root_ff[i][RW-2:0], 1'b1};
         end else begin
            sq_rem_in[i+1]  = sq_rsh[i];
            sq_root_in[i+1] = {sq_root_ff[i][RW-2:0], 1'b0};
         end
      end
   end

   always_comb begin
      root = (sq_root_ff[RW] == '0) ? RW'(1) : sq_root_ff[RW];
      big_sum = (RW+1)'(root) + 1'b1;
      big_x   = (RW+16)'(big_sum[RW:1]);
      num[0]  = sq_job_ff[RW].num_a;
      num[1]  = sq_job_ff[RW].num_b;
      num[2]  = sq_job_ff[RW].num_c;
      dv_valid_in[0] = sq_valid_ff[RW];
      dv_job_in[0]   = sq_job_ff[RW];
      dv_div_in[0]   = {root, 1'b0};
      dv_big_in[0]   = (big_x > (RW+16)'(32767)) ? 16'h7FFF : big_x[15:0];
      for (int k = 0; k < 3; k++) begin
         mag[k]          = num[k][rmq_pkg::NUM_W-1] ? (~num[k] + 1'b1) : num[k];
         dv_rem_in[0][k] = '0;
         dv_nq_in[0][k]  = {mag[k], {F{1'b0}}} + NW'(root);
      end
      for (int j = 0; j < NW; j++) begin
         dv_valid_in[j+1] = dv_valid_ff[j];
         dv_job_in[j+1]   = dv_job_ff[j];
         dv_div_in[j+1]   = dv_div_ff[j];
         dv_big_in[j+1]   = dv_big_ff[j];
         for (int k = 0; k < 3; k++) begin
            dv_rsh[j][k] = {dv_rem_ff[j][k][RW:0], dv_nq_ff[j][k][NW-1]};
            if (dv_rsh[j][k] >= {1'b0, dv_div_ff[j]}) begin
               dv_rem_in[j+1][k] = dv_rsh[j][k] - {1'b0, dv_div_ff[j]};
               dv_nq_in[j+1][k]  = {dv_nq_ff[j][k][NW-2:0], 1'b1};
            end else begin
               dv_rem_in[j+1][k] = dv_rsh[j][k];
               dv_nq_in[j+1][k]  = {dv_nq_ff[j][k][NW-2:0], 1'b0};
            end
         end
      end
   end

   always_comb begin
      quo = '0;
      for (int k = 0; k < 3; k++) begin
         quo = dv_nq_ff[NW][k];
         if (dv_job_ff[NW].num_a[rmq_pkg::NUM_W-1] && k == 0 ||
             dv_job_ff[NW].num_b[rmq_pkg::NUM_W-1] && k == 1 ||
             dv_job_ff[NW].num_c[rmq_pkg::NUM_W-1] && k == 2) begin
            comp[k] = (quo >= NW'(32768)) ? 16'sh8000 : -signed'(quo[15:0]);
         end else begin
            comp[k] = (quo > NW'(32767)) ? 16'sh7FFF : signed'(quo[15:0]);
         end
      end
      big_s          = signed'(dv_big_ff[NW]);
      strobe_in      = dv_valid_ff[NW];
      rsp_in.pos_x   = dv_job_ff[NW].pos_x;
      rsp_in.pos_y   = dv_job_ff[NW].pos_y;
      rsp_in.pos_z   = dv_job_ff[NW].pos_z;
      unique case (dv_job_ff[NW].branch)
         rmq_pkg::BR_TRACE: begin
            rsp_in.quat_x = comp[0];
            rsp_in.quat_y = comp[1];
            rsp_in.quat_z = comp[2];
            rsp_in.quat_w = big_s;
         end
         rmq_pkg::BR_X: begin
            rsp_in.quat_x = big_s;
            rsp_in.quat_y = comp[1];
            rsp_in.quat_z = comp[2];
            rsp_in.quat_w = comp[0];
         end
         rmq_pkg::BR_Y: begin
            rsp_in.quat_x = comp[1];
            rsp_in.quat_y = big_s;
            rsp_in.quat_z = comp[2];
            rsp_in.quat_w = comp[0];
         end
         default: begin
            rsp_in.quat_x = comp[1];
            rsp_in.quat_y = comp[2];
            rsp_in.quat_z = big_s;
            rsp_in.quat_w = comp[0];
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= RW; i++) begin
            sq_valid_ff[i] <= 1'b0;
         end
         for (int j = 0; j <= NW; j++) begin
            dv_valid_ff[j] <= 1'b0;
         end
         strobe_ff <= 1'b0;
      end else begin
         for (int i = 0; i <= RW; i++) begin
            sq_valid_ff[i] <= sq_valid_in[i];
         end
         for (int j = 0; j <= NW; j++) begin
            dv_valid_ff[j] <= dv_valid_in[j];
         end
         strobe_ff <= strobe_in;
      end
      for (int i = 0; i <= RW; i++) begin
         sq_rem_ff[i]  <= sq_rem_in[i];
         sq_root_ff[i] <= sq_root_in[i];
         sq_arg_ff[i]  <= sq_arg_in[i];
         sq_job_ff[i]  <= sq_job_in[i];
      end
      for (int j = 0; j <= NW; j++) begin
         dv_job_ff[j] <= dv_job_in[j];
         dv_div_ff[j] <= dv_div_in[j];
         dv_big_ff[j] <= dv_big_in[j];
         for (int k = 0; k < 3; k++) begin
            dv_rem_ff[j][k] <= dv_rem_in[j][k];
            dv_nq_ff[j][k]  <= dv_nq_in[j][k];
         end
      end
      rsp_ff <= rsp_in;
   end

   a_strobe_follows : assert property (@(posedge clock) disable iff (reset)
      strobe_ff |-> $past(dv_valid_ff[NW])) else $error("Strobe without a transaction.");
   a_root_nonzero : assert property (@(posedge clock) disable iff (reset)
      sq_valid_ff[RW] |-> (sq_root_ff[RW] != '0)) else $error("Square root is zero.");
   a_div_nonzero : assert property (@(posedge clock) disable iff (reset)
      dv_valid_ff[0] |-> (dv_div_ff[0] != '0)) else $error("Divisor is zero.");

endmodule

`default_nettype wire

[hdl/rotation_matrix_to_quaternion_unit.sv]
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion unit
// Converts a rigid pose matrix to a translation and a saturated quaternion
// by the trace and largest-diagonal method.
//
//   Channel   Ports                      Handshake
//   request   start, busy, req_item      taken when start and not busy
//   response  rsp_strobe, rsp_item       one cycle per transaction
//
// One transaction can be taken every cycle. Each result passes the front
// end register, the job queue, the bit-per-stage square root, the three
// bit-per-stage dividers and the output register. Reset is synchronous and
// clears all valid flags. The receiver cannot stall, so busy only rises if
// the job queue fills.
// ----------------------------------------------------------------------------
`default_nettype none

module rotation_matrix_to_quaternion_unit #(
   parameter int ROT_FRAC_BITS = rmq_pkg::ROT_FRAC_BITS_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire rmq_pkg::req_type req_item,
   output logic                  rsp_strobe,
   output rmq_pkg::rsp_type      rsp_item
);

   localparam int DW  = ((ROT_FRAC_BITS > 17) ? ROT_FRAC_BITS : 17) + 1;
   localparam int JW  = $bits(rmq_pkg::job_type);
   localparam int QW  = JW + DW;

   rmq_pkg::job_type job_f, job_b;
   logic [DW-1:0]    d_f, d_b;
   logic             q_push, q_full, q_empty;
   logic [QW-1:0]    q_out;

   rmq_front #(
      .ROT_FRAC_BITS(ROT_FRAC_BITS),
      .DW(DW)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_item(req_item),
      .q_full(q_full),
      .q_push(q_push),
      .job(job_f),
      .d_val(d_f)
   );

   rmq_queue #(
      .DATA_W(QW)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .push(q_push),
      .push_data({job_f, d_f}),
      .pop(!q_empty),
      .pop_data(q_out),
      .empty(q_empty),
      .full(q_full)
   );

   assign job_b = q_out[QW-1:DW];
   assign d_b   = q_out[DW-1:0];

   rmq_back #(
      .ROT_FRAC_BITS(ROT_FRAC_BITS),
      .DW(DW)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .in_valid(!q_empty),
      .in_job(job_b),
      .in_d(d_b),
      .rsp_strobe(rsp_strobe),
      .rsp_item(rsp_item)
   );

endmodule

`default_nettype wire
